>>> rtl/kss_pkg.sv
package kss_pkg;

    // Default geometry of the table.
    localparam int DEF_SLOT_COUNT = 32;
    localparam int DEF_KEY_BYTES  = 8;

    // Widest slot index and count that the largest supported table needs.
    localparam int IDX_MAX_W = 8;
    localparam int CNT_MAX_W = 9;

    localparam int KEY_W   = 64;
    localparam int STATE_W = 8;
    localparam int OWNER_W = 32;

    // Request codes.
    localparam logic [2:0] ACT_FIND        = 3'd0;
    localparam logic [2:0] ACT_FIND_ASSIGN = 3'd1;
    localparam logic [2:0] ACT_GET         = 3'd2;
    localparam logic [2:0] ACT_SET         = 3'd3;
    localparam logic [2:0] ACT_SEED        = 3'd4;
    localparam logic [2:0] ACT_REAP        = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_NEW     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // "status/" in the low seven bytes, first character lowest.
    localparam logic [KEY_W-1:0] STATUS_PREFIX      = 64'h002F_7375_7461_7473;
    localparam logic [KEY_W-1:0] STATUS_PREFIX_MASK = 64'h00FF_FFFF_FFFF_FFFF;

    // A request walking down the row of slot cells, gathering scan results.
    typedef struct packed {
        logic                 valid;
        logic [2:0]           action;
        logic [KEY_W-1:0]     key;
        logic [STATE_W-1:0]   want;
        logic [OWNER_W-1:0]   owner;
        logic                 hit;
        logic [IDX_MAX_W-1:0] hit_idx;
        logic [STATE_W-1:0]   hit_state;
        logic [OWNER_W-1:0]   hit_owner;
        logic                 free_seen;
        logic [IDX_MAX_W-1:0] open_idx;
        logic [CNT_MAX_W-1:0] reaped;
    } t_tok;

    // Write-back of one slot at the end of a request.
    typedef struct packed {
        logic                 en;
        logic [IDX_MAX_W-1:0] idx;
        logic [KEY_W-1:0]     key;
        logic [STATE_W-1:0]   state;
        logic [OWNER_W-1:0]   owner;
    } t_wr;

endpackage

>>> rtl/kss_cell.sv
module kss_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kss_pkg::t_tok i_tok,
    input  kss_pkg::t_wr  i_wr,
    output kss_pkg::t_tok o_tok
);
    import kss_pkg::*;

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_IDX);

    logic [KEY_W-1:0]   r_key;
    logic [STATE_W-1:0] r_state;
    logic [OWNER_W-1:0] r_owner;
    t_tok               r_tok;
    t_tok               n_tok;

    logic w_used;
    logic w_reap_hit;
    logic w_is_reap;
    logic w_wr_me;

    assign w_used    = (r_key[7:0] != 8'd0);
    assign w_is_reap = (i_tok.action == ACT_REAP);
    assign w_wr_me   = i_wr.en && (i_wr.idx == MY_IDX);
    assign w_reap_hit = i_tok.valid && w_is_reap && w_used && (r_owner != '0)
                        && ((r_key & STATUS_PREFIX_MASK) == STATUS_PREFIX)
                        && (r_owner == i_tok.owner);

    always_comb begin
        n_tok = i_tok;
        if (w_is_reap) begin
            if (w_reap_hit && (r_state != '0)) begin
                n_tok.reaped = i_tok.reaped + CNT_MAX_W'(1);
            end
        end else if (!i_tok.hit) begin
            // Only the first free slot before any match is remembered.
            if (!w_used) begin
                if (!i_tok.free_seen) begin
                    n_tok.free_seen = 1'b1;
                    n_tok.open_idx  = MY_IDX;
                end
            end else if (r_key == i_tok.key) begin
                n_tok.hit       = 1'b1;
                n_tok.hit_idx   = MY_IDX;
                n_tok.hit_state = r_state;
                n_tok.hit_owner = r_owner;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_state     <= '0;
            r_owner     <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_wr_me) begin
                r_key   <= i_wr.key;
                r_state <= i_wr.state;
                r_owner <= i_wr.owner;
            end else if (w_reap_hit) begin
                r_state <= '0;
                r_owner <= '0;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

>>> rtl/keyed_slot_state_table_top.sv
// Channel   Direction  Handshake             Fields
// request   in         start & !busy         i_action i_key i_new_state i_owner_id
// result    out        o_valid, one cycle    o_status o_slot_index o_state_out
//                                            o_changed o_reaped_count o_used_extent
//
// A request is registered on acceptance and then walks the row of slot cells one cell per cycle;
// after the last cell it is decided, its slot is written back and the result strobe is registered.
// busy is high from the acceptance edge until the result strobe; a new request may be
// given in the strobe cycle. Reset clears every slot and the high-water mark at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
module keyed_slot_state_table_top #(
    parameter int SLOT_COUNT = kss_pkg::DEF_SLOT_COUNT,
    parameter int KEY_BYTES  = kss_pkg::DEF_KEY_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_action,
    input  logic [63:0]       i_key,
    input  logic signed [8:0] i_new_state,
    input  logic [31:0]       i_owner_id,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [4:0]        o_slot_index,
    output logic [7:0]        o_state_out,
    output logic              o_changed,
    output logic [5:0]        o_reaped_count,
    output logic [5:0]        o_used_extent
);
    import kss_pkg::*;

    localparam int HW_W = $clog2(SLOT_COUNT + 1);

    t_tok w_chain [SLOT_COUNT+1];
    t_tok r_tok0;
    t_tok w_last;
    t_wr  w_wr;

    logic              r_busy;
    logic [HW_W-1:0]   r_hw;
    logic [HW_W-1:0]   n_hw;
    logic [KEY_W-1:0]  w_norm_key;
    logic              w_accept;

    // Key bytes after the first zero byte count as zero.
    always_comb begin
        logic stop;
        stop       = 1'b0;
        w_norm_key = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < KEY_BYTES) begin
                if (i_key[8*b +: 8] == 8'd0) begin
                    stop = 1'b1;
                end
                if (!stop) begin
                    w_norm_key[8*b +: 8] = i_key[8*b +: 8];
                end
            end
        end
    end

    assign w_accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.valid <= 1'b0;
        end else begin
            r_tok0.valid <= w_accept;
            if (w_accept) begin
                r_tok0.action    <= i_action;
                r_tok0.key       <= w_norm_key;
                r_tok0.want      <= i_new_state[8] ? 8'd0 : i_new_state[7:0];
                r_tok0.owner     <= i_owner_id;
                r_tok0.hit       <= 1'b0;
                r_tok0.hit_idx   <= '0;
                r_tok0.hit_state <= '0;
                r_tok0.hit_owner <= '0;
                r_tok0.free_seen <= 1'b0;
                r_tok0.open_idx  <= '0;
                r_tok0.reaped    <= '0;
            end
        end
    end

    assign w_chain[0] = r_tok0;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        kss_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_chain[g]),
            .i_wr    (w_wr),
            .o_tok   (w_chain[g+1])
        );
    end

    assign w_last = w_chain[SLOT_COUNT];

    // Decision on the request that has left the last cell.
    logic                 w_is_reap;
    logic                 w_is_lookup;
    logic                 w_may_assign;
    logic                 w_do_assign;
    logic                 w_do_set;
    logic [1:0]           w_status;
    logic [IDX_MAX_W-1:0] w_idx;
    logic [STATE_W-1:0]   w_state;
    logic                 w_changed;
    logic [CNT_MAX_W-1:0] w_extent;

    assign w_is_reap    = (w_last.action == ACT_REAP);
    assign w_is_lookup  = (w_last.action <= ACT_SEED) && (w_last.key != '0);
    assign w_may_assign = (w_last.action == ACT_FIND_ASSIGN) || (w_last.action == ACT_SET)
                          || (w_last.action == ACT_SEED);
    assign w_do_assign  = w_is_lookup && !w_last.hit && w_may_assign && w_last.free_seen;
    assign w_do_set     = w_is_lookup && w_last.hit && (w_last.action == ACT_SET);
    assign w_extent     = CNT_MAX_W'(w_last.open_idx) + CNT_MAX_W'(1);

    always_comb begin
        w_status  = ST_MISSING;
        w_idx     = '0;
        w_state   = '0;
        w_changed = 1'b0;
        priority if (w_is_reap) begin
            w_status = ST_FOUND;
        end else if (w_is_lookup && w_last.hit) begin
            w_status  = ST_FOUND;
            w_idx     = w_last.hit_idx;
            w_state   = w_do_set ? w_last.want : w_last.hit_state;
            w_changed = w_do_set && ((w_last.hit_state != w_last.want)
                                     || (w_last.hit_owner != w_last.owner));
        end else if (w_do_assign) begin
            w_status  = ST_NEW;
            w_idx     = w_last.open_idx;
            w_state   = (w_last.action == ACT_FIND_ASSIGN) ? 8'd0 : w_last.want;
            w_changed = 1'b1;
        end else if (w_is_lookup && w_may_assign) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_MISSING;
        end
    end

    always_comb begin
        n_hw = r_hw;
        if (w_last.valid && w_do_assign && (w_extent > CNT_MAX_W'(r_hw))) begin
            n_hw = HW_W'(w_extent);
        end
    end

    // A hit on set state and a fresh assignment both rewrite one slot.
    always_comb begin
        w_wr.en    = w_last.valid && (w_do_assign || w_do_set);
        w_wr.idx   = w_idx;
        w_wr.key   = w_last.key;
        w_wr.state = w_state;
        w_wr.owner = (w_last.action == ACT_FIND_ASSIGN) ? '0 : w_last.owner;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_hw    <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_last.valid;
            r_hw    <= n_hw;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_last.valid) begin
                r_busy <= 1'b0;
            end
            if (w_last.valid) begin
                o_status       <= w_status;
                o_slot_index   <= 5'(w_idx);
                o_state_out    <= w_state;
                o_changed      <= w_changed;
                o_reaped_count <= w_is_reap ? 6'(w_last.reaped) : 6'd0;
                o_used_extent  <= 6'(n_hw);
            end
        end
    end

    assign busy = r_busy;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import kss_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int SLOTS      = DEF_SLOT_COUNT;
    localparam int KEY_LEN    = DEF_KEY_BYTES;
    localparam int RAND_ITEMS = 1890;
    localparam int CALM_TAIL  = 200;
    localparam int POOL_SIZE  = 36;

    // Action codes that the block does not use.
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] slot_index;
        logic [7:0] state_out;
        logic       changed;
        logic [5:0] reaped_count;
        logic [5:0] used_extent;
    } t_res;

    typedef struct {
        logic [2:0]        act;
        logic [63:0]       key;
        logic signed [8:0] new_state;
        logic [31:0]       owner;
        bit                typed;
        t_res              res;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        i_action;
    logic [63:0]       i_key;
    logic signed [8:0] i_new_state;
    logic [31:0]       i_owner_id;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [4:0]        o_slot_index;
    logic [7:0]        o_state_out;
    logic              o_changed;
    logic [5:0]        o_reaped_count;
    logic [5:0]        o_used_extent;

    keyed_slot_state_table_top #(
        .SLOT_COUNT(SLOTS),
        .KEY_BYTES (KEY_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_new_state   (i_new_state),
        .i_owner_id    (i_owner_id),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_state_out   (o_state_out),
        .o_changed     (o_changed),
        .o_reaped_count(o_reaped_count),
        .o_used_extent (o_used_extent)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the table.
    logic [63:0] slot_keys   [SLOTS];
    logic [7:0]  slot_states [SLOTS];
    logic [31:0] slot_owners [SLOTS];
    int          fill_mark;

    t_res        pending_results[$];
    t_row        directed_rows[$];
    logic [63:0] key_pool[POOL_SIZE];
    int          error_count;
    int          requests_sent;
    int          status_seen[4];
    int          reaped_total;
    bit          quiet;

    function automatic t_res predict_table(input logic [2:0] act, input logic [63:0] raw_key,
                                           input logic signed [8:0] ns,
                                           input logic [31:0] owner);
        t_res        r;
        logic [63:0] k;
        logic [7:0]  want;
        int          hit;
        int          free_slot;
        bit          ended;
        r = '0;
        r.status = ST_MISSING;
        k = '0;
        ended = 1'b0;
        // Bytes after the first zero byte do not belong to the key.
        for (int b = 0; b < KEY_LEN; b++) begin
            if (raw_key[8*b +: 8] == 8'd0) ended = 1'b1;
            if (!ended) k[8*b +: 8] = raw_key[8*b +: 8];
        end
        want = ns[8] ? 8'd0 : ns[7:0];
        if (act == ACT_REAP) begin
            r.status = ST_FOUND;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_keys[i][7:0] != 8'd0 && slot_owners[i] != 32'd0 &&
                    (slot_keys[i] & STATUS_PREFIX_MASK) == STATUS_PREFIX &&
                    slot_owners[i] == owner) begin
                    if (slot_states[i] != 8'd0) begin
                        slot_states[i] = 8'd0;
                        r.reaped_count = r.reaped_count + 6'd1;
                    end
                    slot_owners[i] = 32'd0;
                end
            end
        end else if (act <= ACT_SEED && k != 64'd0) begin
            hit = -1;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_keys[i][7:0] == 8'd0) begin
                    if (free_slot < 0) free_slot = i;
                end else if (hit < 0 && slot_keys[i] == k) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                r.status = ST_FOUND;
                if (act == ACT_SET) begin
                    r.changed = (slot_states[hit] != want || slot_owners[hit] != owner);
                    slot_states[hit] = want;
                    slot_owners[hit] = owner;
                end
            end else if (act == ACT_FIND_ASSIGN || act == ACT_SET || act == ACT_SEED) begin
                if (free_slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    hit = free_slot;
                    slot_keys[hit]   = k;
                    slot_states[hit] = (act == ACT_FIND_ASSIGN) ? 8'd0 : want;
                    slot_owners[hit] = (act == ACT_FIND_ASSIGN) ? 32'd0 : owner;
                    if (hit + 1 > fill_mark) fill_mark = hit + 1;
                    r.status  = ST_NEW;
                    r.changed = 1'b1;
                end
            end
            if (hit >= 0) begin
                r.slot_index = hit[4:0];
                r.state_out  = slot_states[hit];
            end
        end
        r.used_extent = fill_mark[5:0];
        return r;
    endfunction

    task automatic add_row(input logic [2:0] act, input logic [63:0] key,
                           input logic signed [8:0] ns, input logic [31:0] owner,
                           input bit typed, input t_res res);
        t_row row;
        row.act       = act;
        row.key       = key;
        row.new_state = ns;
        row.owner     = owner;
        row.typed     = typed;
        row.res       = res;
        directed_rows.push_back(row);
    endtask

    // Presents one request and returns at the edge that accepts it.
    task automatic issue_request(input logic [2:0] act, input logic [63:0] key,
                                 input logic signed [8:0] ns, input logic [31:0] owner,
                                 input bit typed, input t_res typed_res);
        t_res predicted;
        i_action    <= act;
        i_key       <= key;
        i_new_state <= ns;
        i_owner_id  <= owner;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = predict_table(act, key, ns, owner);
        pending_results.push_back(typed ? typed_res : predicted);
        requests_sent++;
    endtask

    // Drops start and scrambles the request fields, which must be ignored meanwhile.
    task automatic hold_off(input int cycles, input bit after_result);
        start       <= 1'b0;
        i_action    <= 3'($urandom);
        i_key       <= {$urandom, $urandom};
        i_new_state <= 9'($urandom);
        i_owner_id  <= $urandom;
        if (after_result) begin
            while (pending_results.size() != 0) @(posedge i_clk);
        end
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_pause(input bit allowed);
        if (allowed && !quiet && $urandom_range(0, 99) < 30)
            hold_off($urandom_range(1, 15), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [2:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) return ACT_FIND;
        if (r < 28) return ACT_FIND_ASSIGN;
        if (r < 42) return ACT_GET;
        if (r < 66) return ACT_SET;
        if (r < 80) return ACT_SEED;
        if (r < 96) return ACT_REAP;
        if (r < 98) return ACT_SPARE6;
        return ACT_SPARE7;
    endfunction

    function automatic logic [31:0] pick_owner();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 32'($urandom_range(1, 4)) + ((r % 4 == 0) ? 32'd1 : 32'd0);
        if (r < 80) return 32'hFFFF_FFFF;
        if (r < 85) return 32'd0;
        return $urandom;
    endfunction

    function automatic logic signed [8:0] pick_state();
        if ($urandom_range(0, 99) < 40) return 9'($urandom_range(0, 3));
        return 9'($urandom_range(0, 511));
    endfunction

    task automatic build_key_pool();
        logic [63:0] k;
        logic [7:0]  b;
        key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        key_pool[1] = 64'h612F_7375_7461_7473;
        key_pool[2] = 64'h622F_7375_7461_7473;
        key_pool[3] = STATUS_PREFIX;
        for (int i = 4; i < 14; i++)
            key_pool[i] = STATUS_PREFIX | (64'($urandom_range(0, 255)) << 56);
        // Keys that miss the status prefix only in its last character.
        for (int i = 14; i < 17; i++) begin
            b = 8'($urandom_range(1, 255));
            if (b == 8'h2F) b = 8'h2E;
            key_pool[i] = {8'($urandom), b, STATUS_PREFIX[47:0]};
        end
        for (int i = 17; i < POOL_SIZE; i++) begin
            k = {$urandom, $urandom};
            k[7:0] = 8'($urandom_range(1, 255));
            if ($urandom_range(0, 2) == 0) k[8 * $urandom_range(1, 7) +: 8] = 8'd0;
            key_pool[i] = k;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request waiting, expected nothing, got status %0d",
                         $time, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("slot_index", want.slot_index, o_slot_index);
                check_field("state_out", want.state_out, o_state_out);
                check_field("changed", want.changed, o_changed);
                check_field("reaped_count", want.reaped_count, o_reaped_count);
                check_field("used_extent", want.used_extent, o_used_extent);
                status_seen[o_status]++;
                reaped_total += o_reaped_count;
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [63:0] k;
        logic [2:0]  act;
        int          lim;
        int          waited;
        int          r;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_action    <= ACT_FIND;
        i_key       <= 64'd0;
        i_new_state <= 9'sd0;
        i_owner_id  <= 32'd0;
        error_count = 0;
        requests_sent = 0;
        reaped_total = 0;
        quiet = 1'b0;
        fill_mark = 0;
        for (int i = 0; i < 4; i++) status_seen[i] = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_keys[i]   = 64'd0;
            slot_states[i] = 8'd0;
            slot_owners[i] = 32'd0;
        end

        // Directed requests; typed results are the obvious ones.
        add_row(ACT_FIND, 64'h0000_0000_0063_6261, 9'sd0, 32'd0, 1,
                '{ST_MISSING, 5'd0, 8'd0, 1'b0, 6'd0, 6'd0});
        add_row(ACT_GET, 64'h0000_0000_0063_6261, 9'sd0, 32'd0, 1,
                '{ST_MISSING, 5'd0, 8'd0, 1'b0, 6'd0, 6'd0});
        add_row(ACT_FIND_ASSIGN, 64'd0, 9'sd0, 32'd0, 1,
                '{ST_MISSING, 5'd0, 8'd0, 1'b0, 6'd0, 6'd0});
        // An empty first byte hides the rest of the key.
        add_row(ACT_SET, 64'hFFFF_FFFF_FFFF_FF00, 9'sd5, 32'd1, 1,
                '{ST_MISSING, 5'd0, 8'd0, 1'b0, 6'd0, 6'd0});
        add_row(ACT_FIND_ASSIGN, 64'hFFFF_FFFF_FFFF_FFFF, 9'sd0, 32'd0, 1,
                '{ST_NEW, 5'd0, 8'd0, 1'b1, 6'd0, 6'd1});
        add_row(ACT_SET, 64'hFFFF_FFFF_FFFF_FFFF, 9'sd255, 32'hFFFF_FFFF, 1,
                '{ST_FOUND, 5'd0, 8'd255, 1'b1, 6'd0, 6'd1});
        add_row(ACT_SET, 64'hFFFF_FFFF_FFFF_FFFF, 9'sd255, 32'hFFFF_FFFF, 1,
                '{ST_FOUND, 5'd0, 8'd255, 1'b0, 6'd0, 6'd1});
        add_row(ACT_SEED, 64'h612F_7375_7461_7473, -9'sd256, 32'd5, 1,
                '{ST_NEW, 5'd1, 8'd0, 1'b1, 6'd0, 6'd2});
        add_row(ACT_SEED, 64'h612F_7375_7461_7473, 9'sd7, 32'd9, 1,
                '{ST_FOUND, 5'd1, 8'd0, 1'b0, 6'd0, 6'd2});
        add_row(ACT_SET, 64'h612F_7375_7461_7473, 9'sd9, 32'd5, 0, '0);
        add_row(ACT_SET, 64'h622F_7375_7461_7473, 9'sd200, 32'd5, 0, '0);
        add_row(ACT_SET, 64'h632F_7375_7461_7473, 9'sd0, 32'd5, 0, '0);
        add_row(ACT_SEED, STATUS_PREFIX, 9'sd1, 32'd5, 0, '0);
        add_row(ACT_SET, 64'h6158_7375_7461_7473, 9'sd50, 32'd5, 0, '0);
        add_row(ACT_FIND_ASSIGN, 64'h0000_0064_6300_6261, 9'sd0, 32'd0, 0, '0);
        add_row(ACT_FIND, 64'h0000_0000_0000_6261, 9'sd0, 32'd0, 0, '0);
        add_row(ACT_SET, 64'h0000_0000_0000_6261, 9'sd0, 32'd0, 0, '0);
        add_row(ACT_SET, 64'h0000_0000_0000_6261, -9'sd1, 32'd0, 0, '0);
        add_row(ACT_REAP, 64'd0, 9'sd0, 32'd0, 1,
                '{ST_FOUND, 5'd0, 8'd0, 1'b0, 6'd0, 6'd7});
        add_row(ACT_REAP, 64'd0, 9'sd0, 32'd6, 1,
                '{ST_FOUND, 5'd0, 8'd0, 1'b0, 6'd0, 6'd7});
        add_row(ACT_REAP, 64'hFFFF_FFFF_FFFF_FFFF, 9'sd0, 32'd5, 1,
                '{ST_FOUND, 5'd0, 8'd0, 1'b0, 6'd3, 6'd7});
        add_row(ACT_REAP, 64'd0, 9'sd0, 32'd5, 1,
                '{ST_FOUND, 5'd0, 8'd0, 1'b0, 6'd0, 6'd7});
        add_row(ACT_GET, 64'h6158_7375_7461_7473, 9'sd0, 32'd0, 0, '0);
        add_row(ACT_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF, 9'sd255, 32'd5, 1,
                '{ST_MISSING, 5'd0, 8'd0, 1'b0, 6'd0, 6'd7});
        add_row(ACT_SPARE7, 64'h612F_7375_7461_7473, -9'sd256, 32'd5, 1,
                '{ST_MISSING, 5'd0, 8'd0, 1'b0, 6'd0, 6'd7});
        add_row(ACT_GET, 64'h622F_7375_7461_7473, 9'sd0, 32'd0, 0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            issue_request(directed_rows[n].act, directed_rows[n].key,
                          directed_rows[n].new_state, directed_rows[n].owner,
                          directed_rows[n].typed, directed_rows[n].res);
            maybe_pause(1'b1);
        end

        // Random requests mostly hit a small key pool; the pool widens later
        // so that the table fills up partway through.
        build_key_pool();
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
            lim = (n < RAND_ITEMS * 6 / 10) ? 21 : POOL_SIZE - 1;
            act = pick_action();
            r = $urandom_range(0, 99);
            if (r < 4 && lim == POOL_SIZE - 1) begin
                k = {$urandom, $urandom};
            end else if (r < 8) begin
                k = {$urandom, $urandom};
                k[7:0] = 8'd0;
            end else begin
                k = key_pool[$urandom_range(0, lim)];
            end
            issue_request(act, k, pick_state(), pick_owner(), 1'b0, '0);
            maybe_pause(n < RAND_ITEMS - CALM_TAIL);
        end

        // Make sure the table runs out of free slots.
        for (int f = 0; f <= SLOTS; f++)
            issue_request(ACT_FIND_ASSIGN, 64'h0000_0000_6C6C_6966 | (64'(f + 1) << 32),
                          9'sd0, 32'd0, 1'b0, '0);

        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 8 * (SLOTS + 2)) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SLOTS + 4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived, expected %0d more, got none",
                     $time, pending_results.size(), pending_results.size());
            error_count += pending_results.size();
        end

        $display("Sent %0d requests: %0d found, %0d newly assigned, %0d missing, %0d full.",
                 requests_sent, status_seen[ST_FOUND], status_seen[ST_NEW],
                 status_seen[ST_MISSING], status_seen[ST_FULL]);
        $display("Reaps cleared %0d status slots; final used extent %0d of %0d slots.",
                 reaped_total, fill_mark, SLOTS);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/kss_pkg.sv
rtl/kss_cell.sv
rtl/keyed_slot_state_table_top.sv
verif/tb.sv
